/* src/bqk_pkg.sv */
`timescale 1ns / 1ps

package bqk_pkg;

  localparam int MAX_LEVELS = 28;
  localparam int ZOOM_W     = 5;
  localparam int KEY_W      = 64;
  localparam int COORD_W    = 32;
  localparam int TILE_W     = 28;
  localparam int SHIFT_W    = 6;
  localparam int MSHIFT_W   = 7;
  // bit position of the x bit in the top interleaved pair
  localparam int PAIR_TOP   = KEY_W - ZOOM_W - 2;

  typedef enum logic [1:0] {
    OP_BBOX   = 2'd0,
    OP_TILE   = 2'd1,
    OP_DECODE = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]           op;
    logic [COORD_W-1:0]   corner_x_first;
    logic [COORD_W-1:0]   corner_y_first;
    logic [COORD_W-1:0]   corner_x_second;
    logic [COORD_W-1:0]   corner_y_second;
    logic [TILE_W-1:0]    tile_x;
    logic [TILE_W-1:0]    tile_y;
    logic [ZOOM_W-1:0]    label_zoom;
    logic [ZOOM_W-1:0]    cell_zoom;
    logic [KEY_W-1:0]     code_in;
  } req_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]     key_start;
    logic [KEY_W-1:0]     key_end;
    logic [ZOOM_W-1:0]    zoom_out;
    logic [COORD_W-1:0]   x_out;
    logic [COORD_W-1:0]   y_out;
  } rsp_item_t;

endpackage

/* src/bqk_ifs.sv */
`timescale 1ns / 1ps

interface bqk_req_if;
  import bqk_pkg::*;

  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bqk_rsp_if;
  import bqk_pkg::*;

  logic      valid;
  logic      ready;
  rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/bbox_quadkey_codec.sv */
`timescale 1ns / 1ps
// quadkey codec for 32-bit world coordinates
// req channel: op selects encode bbox, encode tile range or decode key; the
//   other fields are used by the op that needs them
// rsp channel: exactly one result item per request item, in order
// a request accepted into the input stage register moves on to the result
//   register when the output is free; one item per cycle sustained while rsp.ready is high
// the work sits between an input stage register and the result register;
//   the path is an interleave network, a 28-bit leading-agree search and a
//   32-bit barrel shift
// stall: while rsp.ready is low the result register holds; the input stage
//   still takes one more item and req.ready drops when both stages are full
// reset: rst is synchronous and empties both stages; no state otherwise
module bbox_quadkey_codec (
  input  logic            clk,
  input  logic            rst,
  bqk_req_if.sink         req,
  bqk_rsp_if.source       rsp
);
  import bqk_pkg::*;

  logic      stage_valid;
  req_item_t stage_data;
  logic      res_valid;
  rsp_item_t res_data;
  rsp_item_t res_data_next;
  logic      res_free;

  function automatic logic [KEY_W-1:0] interleave(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y);
    logic [KEY_W-1:0] key;
    key = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      key[PAIR_TOP + 1 - 2*i] = y[COORD_W - 1 - i];
      key[PAIR_TOP - 2*i]     = x[COORD_W - 1 - i];
    end
    return key;
  endfunction

  assign res_free  = !res_valid || rsp.ready;
  assign req.ready = !stage_valid || res_free;
  assign rsp.valid = res_valid;
  assign rsp.data  = res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (req.ready) begin
        stage_valid <= req.valid;
      end
      if (res_free) begin
        res_valid <= stage_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stage_data <= req.data;
    end
    if (res_free && stage_valid) begin
      res_data <= res_data_next;
    end
  end

  always_comb begin
    logic [COORD_W-1:0]   diff;
    logic [ZOOM_W-1:0]    zoom;
    logic [SHIFT_W-1:0]   sh;
    logic [COORD_W-1:0]   wx;
    logic [COORD_W-1:0]   wy;
    logic [MSHIFT_W-1:0]  mshift;
    logic [KEY_W-1:0]     mask;

    res_data_next = '0;
    diff   = (stage_data.corner_x_first ^ stage_data.corner_x_second) |
             (stage_data.corner_y_first ^ stage_data.corner_y_second);
    zoom   = ZOOM_W'(MAX_LEVELS);
    // first disagreeing bit from the top sets the zoom
    for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
      if (diff[COORD_W - 1 - i]) begin
        zoom = ZOOM_W'(i);
      end
    end
    sh     = '0;
    wx     = '0;
    wy     = '0;
    mshift = '0;
    mask   = '0;

    case (stage_data.op)
      OP_BBOX: begin
        sh = SHIFT_W'(COORD_W) - {1'b0, zoom};
        res_data_next.key_start = {zoom, {(KEY_W - ZOOM_W){1'b0}}} |
          interleave(stage_data.corner_x_first, stage_data.corner_y_first);
        res_data_next.zoom_out = zoom;
        if (zoom != '0) begin
          res_data_next.x_out = stage_data.corner_x_first >> sh;
          res_data_next.y_out = stage_data.corner_y_first >> sh;
        end
      end
      OP_TILE: begin
        sh = SHIFT_W'(COORD_W) - {1'b0, stage_data.cell_zoom};
        if (stage_data.cell_zoom != '0) begin
          wx = COORD_W'(stage_data.tile_x) << sh;
          wy = COORD_W'(stage_data.tile_y) << sh;
        end
        mshift = {1'b0, stage_data.cell_zoom, 1'b0} + MSHIFT_W'(ZOOM_W);
        if (mshift < MSHIFT_W'(KEY_W)) begin
          mask = {KEY_W{1'b1}} >> mshift;
        end
        res_data_next.key_start = {stage_data.label_zoom, {(KEY_W - ZOOM_W){1'b0}}} |
                                  interleave(wx, wy);
        res_data_next.key_end   = res_data_next.key_start | mask;
      end
      OP_DECODE: begin
        res_data_next.zoom_out = stage_data.code_in[KEY_W-1 -: ZOOM_W];
        for (int i = 0; i < MAX_LEVELS; i++) begin
          res_data_next.y_out[COORD_W - 1 - i] = stage_data.code_in[PAIR_TOP + 1 - 2*i];
          res_data_next.x_out[COORD_W - 1 - i] = stage_data.code_in[PAIR_TOP - 2*i];
        end
      end
      default: begin
        res_data_next = '0;
      end
    endcase
  end

endmodule

/* src/bqk_checker.sv */
`timescale 1ns / 1ps

module bqk_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input bqk_pkg::rsp_item_t rsp_data
);
  import bqk_pkg::*;

  // a held result keeps its valid
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // a held result keeps its payload
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // an item taken reaches the output via the input stage and result register when the receiver is ready
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
    else $error("item not delivered in time");

  // only tile ranges carry an end key, and they carry no zoom
  a_end_key: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.zoom_out != '0 |-> rsp_data.key_end == '0)
    else $error("end key set on a non-range result");

endmodule

bind bbox_quadkey_codec bqk_checker u_bqk_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
